// File: rtl/core/gaft_pkg.sv
package gaft_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // field widths
    localparam int SLOT_W = 8;
    localparam int ADDR_W = 16;
    localparam int LS_W   = 8;
    localparam int CMP_W  = (LS_W > CNT_W) ? LS_W : CNT_W;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] entry_slot;
        logic [ADDR_W-1:0] group_address;
        logic              comm_flag;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] object_index;
    } t_result;

    typedef struct packed {
        logic              flag;
        logic [ADDR_W-1:0] addr;
    } t_entry;

endpackage

// File: rtl/core/gaft_if.sv
interface gaft_item_if import gaft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SLOT_W-1:0] entry_slot;
    logic [ADDR_W-1:0] group_address;
    logic              comm_flag;

    modport source (output valid, operation, entry_slot, group_address, comm_flag,
                    input ready);
    modport sink   (input valid, operation, entry_slot, group_address, comm_flag,
                    output ready);
endinterface

interface gaft_result_if import gaft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] object_index;

    modport source (output valid, hit, object_index, input ready);
    modport sink   (input valid, hit, object_index, output ready);
endinterface

interface gaft_cfg_if import gaft_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [LS_W-1:0] list_size;

    modport source (output valid, list_size, input ready);
    modport sink   (input valid, list_size, output ready);
endinterface

// File: rtl/core/gaft_engine.sv
module gaft_engine
    import gaft_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    input  logic [CNT_W-1:0] i_entries,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    t_entry r_mem [TABLE_DEPTH];

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_ptr;
    logic [ADDR_W-1:0] r_addr;
    logic             r_hit;
    t_entry           r_rd_data;

    logic req_fire;
    logic wr_en;
    logic match;
    logic slot_ok;
    logic [CNT_W-1:0] last_idx;

    assign req_fire = i_req_valid && o_req_ready;
    assign slot_ok  = CMP_W'(i_req.entry_slot) < CMP_W'(TABLE_DEPTH);
    assign wr_en    = req_fire && (i_req.operation == OP_WRITE) && slot_ok;
    assign match    = r_rd_data.flag && (r_rd_data.addr == r_addr);
    assign last_idx = i_entries - CNT_W'(1);

    // table with one write port and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_req.entry_slot[IDX_W-1:0]] <= '{flag: i_req.comm_flag,
                                                   addr: i_req.group_address};
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan runs from the top entry downwards so the first match is the highest
    always_ff @(posedge i_clk) begin
        if (req_fire && (i_req.operation == OP_LOOKUP)) begin
            r_ptr  <= last_idx[IDX_W-1:0];
            r_addr <= i_req.group_address;
            r_hit  <= 1'b0;
        end else if (r_state == ST_CMP) begin
            if (match) begin
                r_hit <= 1'b1;
            end else if (r_ptr != '0) begin
                r_ptr <= r_ptr - IDX_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid && (i_req.operation == OP_LOOKUP)) begin
                    n_state = (i_entries == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (match || (r_ptr == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready       = 1'b0;
        o_res_valid       = 1'b0;
        o_res.hit         = r_hit;
        o_res.object_index = r_hit ? SLOT_W'(r_ptr) : '0;
        case (r_state)
            // no item taken while reset is held
            ST_IDLE: o_req_ready = i_rst_n;
            ST_DONE: o_res_valid = 1'b1;
            default: begin
                o_req_ready = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/group_address_filter_table.sv
// Group address filter table.
// Write item: written to the table, no result; the block stays ready for another item.
// Lookup item: each entry scanned takes a table read, then a compare, from the
// top entry in use downwards, stopping at the first flagged match or at entry 0.
// Result passes from the done state through an output register to the result channel.
// Synchronous active-low reset clears list_size, the sequencer and the output valid.
module group_address_filter_table
    import gaft_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    gaft_cfg_if.sink      i_cfg,
    gaft_item_if.sink     i_item,
    gaft_result_if.source o_result
);

    // list_size register; writes are taken whenever out of reset
    logic [LS_W-1:0]  r_list_size;
    logic [CNT_W-1:0] entries;

    // output register, parts the scan from the result channel
    logic    r_out_valid;
    t_result r_out;

    t_req    req;
    t_result res;
    logic    res_valid;
    logic    res_ready;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_size <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_list_size <= i_cfg.list_size;
        end
    end

    // entries in use, clamped to the table depth
    assign entries = (CMP_W'(r_list_size) > CMP_W'(TABLE_DEPTH)) ?
                     CNT_W'(TABLE_DEPTH) : CNT_W'(r_list_size);

    assign req.operation     = i_item.operation;
    assign req.entry_slot    = i_item.entry_slot;
    assign req.group_address = i_item.group_address;
    assign req.comm_flag     = i_item.comm_flag;

    gaft_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_item.valid),
        .o_req_ready (i_item.ready),
        .i_req       (req),
        .i_entries   (entries),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // take a new result when the register is empty or being drained
    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.hit          = r_out.hit;
    assign o_result.object_index = r_out.object_index;

endmodule
